@@ design/vsh_pkg.sv @@
// constants, widths and pipeline stage types for the spherical harmonics block
// no dependencies; imported by vector_spherical_harmonics_top
package vsh_pkg;

  localparam int CW   = 32;  // input component width
  localparam int MAGW = 33;  // component magnitude width, the most negative value maps to 2^32
  localparam int PSW  = 6;   // leading one position width
  localparam int NW   = 20;  // normalised magnitude width
  localparam int SQW  = 42;  // squared length width
  localparam int RW   = 21;  // root width, one sqrt stage per root bit
  localparam int NUMW = 44;  // signed numerator width
  localparam int MW   = 43;  // numerator magnitude width
  localparam int LOW  = 22;  // low slice of the magnitude for the split multiply
  localparam int KW   = 20;  // constant width, unsigned q0.20
  localparam int DW   = 47;  // doubled scaled divisor width
  localparam int PW   = 65;  // dividend width
  localparam int QW   = 17;  // quotient width, one divider stage per bit
  localparam int OW   = 18;  // result width, signed q1.16

  localparam logic [KW-1:0] K00 = 20'd295798;
  localparam logic [KW-1:0] K10 = 20'd512337;
  localparam logic [KW-1:0] K11 = 20'd362277;
  localparam logic [KW-1:0] K20 = 20'd330712;
  localparam logic [KW-1:0] K21 = 20'd810076;
  localparam logic [KW-1:0] K22 = 20'd405038;

  // y(0,0) = round(k00 / 16), independent of the length
  localparam logic signed [OW-1:0] Y00_VAL = 18'sd18487;

  localparam logic [1:0] ORDER_0    = 2'd0;
  localparam logic [1:0] ORDER_1    = 2'd1;
  localparam logic [1:0] ORDER_2    = 2'd2;
  localparam logic [1:0] ORDER_NONE = 2'd3;

  typedef struct packed {
    logic              vld;
    logic signed [2:0] m;
    logic [1:0]        l;
    logic              last;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [2:0]      neg;
    logic [MAGW-1:0] ax, ay, az, mx;
  } mag_t;

  typedef struct packed {
    tag_t            tag;
    logic [2:0]      neg;
    logic [MAGW-1:0] ax, ay, az;
    logic [PSW-1:0]  msb;
    logic            zero;
  } msb_t;

  typedef struct packed {
    tag_t                tag;
    logic                zero;
    logic [NW-1:0]       ax, ay, az;
    logic signed [NW:0]  sx, sy, sz;
  } nrm_t;

  typedef struct packed {
    tag_t                  tag;
    logic                  zero;
    logic [2*NW-1:0]       xx, yy, zz;
    logic signed [2*NW+1:0] xy, xz, yz;
    logic signed [NW:0]    sx, sy, sz;
  } prd_t;

  typedef struct packed {
    tag_t                   tag;
    logic                   zero;
    logic [SQW-1:0]         r2;
    logic signed [NUMW-1:0] num_re, num_im;
    logic [KW-1:0]          k;
    logic [SQW-1:0]         rem;
    logic [SQW-1:0]         res;
  } sq_t;

  typedef struct packed {
    tag_t          tag;
    logic          zero;
    logic          neg_re, neg_im;
    logic [MW-1:0] mag_re, mag_im;
    logic [KW-1:0] k;
    logic [DW-1:0] d2;
  } pm_t;

  typedef struct packed {
    tag_t                   tag;
    logic                   zero;
    logic                   neg_re, neg_im;
    logic [LOW+KW-1:0]      lo_re, lo_im;
    logic [MW-LOW+KW-1:0]   hi_re, hi_im;
    logic [DW-1:0]          d2;
  } pp_t;

  typedef struct packed {
    tag_t          tag;
    logic          zero;
    logic          neg_re, neg_im;
    logic [DW-1:0] d2;
    logic [PW-1:0] rem_re, rem_im;
    logic [QW-1:0] q_re, q_im;
  } dv_t;

endpackage

@@ design/vector_spherical_harmonics_top.sv @@
// spherical harmonics of order 0..2 for one q16.16 vector per item, deep pipeline
// depends on vsh_pkg for widths, constants and stage types
//
//  channel   ports                                   handshake
//  input     in_vec_x/y/z                            start high, busy low
//  result    out_m_index .. out_zero_length          out_valid strobe, one cycle
//  config    cfg_wr_en, cfg_wr_data                  written on cfg_wr_en
//
//  an item at order l gives 2l+1 tokens at the entry: one token per m value is
//  issued per cycle from the held vector, busy covering the tokens after the first
//  every token then runs the pipeline (normalise, products, 21-stage square root,
//  split multiply, 17-stage divider), so results of one item leave on consecutive
//  cycles; the next item may start the cycle busy falls
//  reset clears the valid bits, the token sequencer and the order register
//  the receiver cannot stall: nothing in the pipeline ever holds
module vector_spherical_harmonics_top
  import vsh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [CW-1:0]  in_vec_x,
  input  logic signed [CW-1:0]  in_vec_y,
  input  logic signed [CW-1:0]  in_vec_z,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_wr_data,
  output logic                  out_valid,
  output logic signed [2:0]     out_m_index,
  output logic signed [OW-1:0]  out_real_part,
  output logic signed [OW-1:0]  out_imag_part,
  output logic                  out_last_of_run,
  output logic                  out_zero_length
);

  logic [1:0] order_r;
  logic       active_r;
  tag_t       s0_r;
  logic signed [CW-1:0] vx_r, vy_r, vz_r;
  logic       accept;

  mag_t s1_r;
  msb_t s2_r;
  nrm_t s3_r;
  prd_t s4_r;
  sq_t  sq_r [RW+1];
  pm_t  pm_r;
  pp_t  pp_r;
  dv_t  dv_r [QW+1];

  assign accept = start && !busy;
  assign busy   = active_r;

  // magnitude of a component; the most negative value counts as 2^32
  function automatic logic [MAGW-1:0] mag_of(logic [CW-1:0] raw);
    if (!raw[CW-1]) return {1'b0, raw};
    if (raw == {1'b1, {(CW-1){1'b0}}}) return {1'b1, {CW{1'b0}}};
    return {1'b0, ~raw + 1'b1};
  endfunction

  // configuration register; the user must write it only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_0;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  // token sequencer: one token per m, from -l up to +l
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r     <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      vx_r      <= in_vec_x;
      vy_r      <= in_vec_y;
      vz_r      <= in_vec_z;
      s0_r.l    <= order_r;
      s0_r.m    <= -$signed({1'b0, order_r});
      s0_r.last <= (order_r == ORDER_0);
      // an undefined order takes the item and gives nothing
      s0_r.vld  <= (order_r != ORDER_NONE);
      active_r  <= (order_r == ORDER_1) || (order_r == ORDER_2);
    end else if (active_r) begin
      s0_r.vld  <= 1'b1;
      s0_r.m    <= s0_r.m + 3'sd1;
      s0_r.last <= ((s0_r.m + 3'sd1) == $signed({1'b0, s0_r.l}));
      active_r  <= ((s0_r.m + 3'sd1) != $signed({1'b0, s0_r.l}));
    end else begin
      s0_r.vld <= 1'b0;
    end
  end

  // stage 1: magnitudes and the largest one
  always_ff @(posedge clk) begin
    logic [MAGW-1:0] ax, ay, az, mx;
    ax = mag_of(vx_r);
    ay = mag_of(vy_r);
    az = mag_of(vz_r);
    mx = (ax > ay) ? ax : ay;
    if (az > mx) mx = az;
    s1_r.tag <= rst_n ? s0_r : tag_t'('0);
    s1_r.neg <= {vx_r[CW-1], vy_r[CW-1], vz_r[CW-1]};
    s1_r.ax  <= ax;
    s1_r.ay  <= ay;
    s1_r.az  <= az;
    s1_r.mx  <= mx;
  end

  // stage 2: leading one of the largest magnitude
  always_ff @(posedge clk) begin
    logic [PSW-1:0] p;
    p = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (s1_r.mx[i]) p = PSW'(i);
    end
    s2_r.tag  <= rst_n ? s1_r.tag : tag_t'('0);
    s2_r.neg  <= s1_r.neg;
    s2_r.ax   <= s1_r.ax;
    s2_r.ay   <= s1_r.ay;
    s2_r.az   <= s1_r.az;
    s2_r.msb  <= p;
    s2_r.zero <= (s1_r.mx == '0);
  end

  // stage 3: common shift so the largest magnitude lands in [2^19, 2^20)
  always_ff @(posedge clk) begin
    logic [NW-1:0]  nx, ny, nz;
    logic [PSW-1:0] sh;
    if (s2_r.msb >= PSW'(NW-1)) begin
      sh = s2_r.msb - PSW'(NW-1);
      nx = NW'(s2_r.ax >> sh);
      ny = NW'(s2_r.ay >> sh);
      nz = NW'(s2_r.az >> sh);
    end else begin
      sh = PSW'(NW-1) - s2_r.msb;
      nx = NW'(s2_r.ax << sh);
      ny = NW'(s2_r.ay << sh);
      nz = NW'(s2_r.az << sh);
    end
    s3_r.tag  <= rst_n ? s2_r.tag : tag_t'('0);
    s3_r.zero <= s2_r.zero;
    s3_r.ax   <= nx;
    s3_r.ay   <= ny;
    s3_r.az   <= nz;
    s3_r.sx   <= s2_r.neg[2] ? -$signed({1'b0, nx}) : $signed({1'b0, nx});
    s3_r.sy   <= s2_r.neg[1] ? -$signed({1'b0, ny}) : $signed({1'b0, ny});
    s3_r.sz   <= s2_r.neg[0] ? -$signed({1'b0, nz}) : $signed({1'b0, nz});
  end

  // stage 4: squares and cross products
  always_ff @(posedge clk) begin
    s4_r.tag  <= rst_n ? s3_r.tag : tag_t'('0);
    s4_r.zero <= s3_r.zero;
    s4_r.xx   <= s3_r.ax * s3_r.ax;
    s4_r.yy   <= s3_r.ay * s3_r.ay;
    s4_r.zz   <= s3_r.az * s3_r.az;
    s4_r.xy   <= s3_r.sx * s3_r.sy;
    s4_r.xz   <= s3_r.sx * s3_r.sz;
    s4_r.yz   <= s3_r.sy * s3_r.sz;
    s4_r.sx   <= s3_r.sx;
    s4_r.sy   <= s3_r.sy;
    s4_r.sz   <= s3_r.sz;
  end

  // stage 5: squared length, numerators and constant for this m
  always_ff @(posedge clk) begin
    logic signed [NUMW-1:0] xx, yy, zz, xy, xz, yz, sx, sy, sz, nre, nim;
    logic [KW-1:0] k;
    xx = $signed({(NUMW-2*NW)'(0), s4_r.xx});
    yy = $signed({(NUMW-2*NW)'(0), s4_r.yy});
    zz = $signed({(NUMW-2*NW)'(0), s4_r.zz});
    xy = NUMW'(s4_r.xy);
    xz = NUMW'(s4_r.xz);
    yz = NUMW'(s4_r.yz);
    sx = NUMW'(s4_r.sx);
    sy = NUMW'(s4_r.sy);
    sz = NUMW'(s4_r.sz);
    nre = '0;
    nim = '0;
    k   = K00;
    case (s4_r.tag.l)
      ORDER_1: begin
        if (s4_r.tag.m == 3'sd0) begin
          nre = sz;
          k   = K10;
        end else begin
          nre = (s4_r.tag.m < 3'sd0) ? sx : -sx;
          nim = -sy;
          k   = K11;
        end
      end
      ORDER_2: begin
        if (s4_r.tag.m == 3'sd0) begin
          nre = (zz <<< 1) - xx - yy;
          k   = K20;
        end else if (s4_r.tag.m == 3'sd1 || s4_r.tag.m == -3'sd1) begin
          nre = (s4_r.tag.m < 3'sd0) ? xz : -xz;
          nim = -yz;
          k   = K21;
        end else begin
          nre = xx - yy;
          nim = (s4_r.tag.m < 3'sd0) ? -(xy <<< 1) : (xy <<< 1);
          k   = K22;
        end
      end
      default: begin
        nre = '0;
      end
    endcase
    sq_r[0].tag    <= rst_n ? s4_r.tag : tag_t'('0);
    sq_r[0].zero   <= s4_r.zero;
    sq_r[0].r2     <= SQW'(s4_r.xx) + SQW'(s4_r.yy) + SQW'(s4_r.zz);
    sq_r[0].rem    <= SQW'(s4_r.xx) + SQW'(s4_r.yy) + SQW'(s4_r.zz);
    sq_r[0].res    <= '0;
    sq_r[0].num_re <= nre;
    sq_r[0].num_im <= nim;
    sq_r[0].k      <= k;
  end

  // square root: one result bit per stage, digit pairs from the top
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (RW - 1 - j));
    logic [SQW:0] trial;
    assign trial = {1'b0, sq_r[j].res} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      sq_t sq_nxt;
      sq_nxt = sq_r[j];
      if ({1'b0, sq_r[j].rem} >= trial) begin
        sq_nxt.rem = sq_r[j].rem - trial[SQW-1:0];
        sq_nxt.res = (sq_r[j].res >> 1) + BIT;
      end else begin
        sq_nxt.res = sq_r[j].res >> 1;
      end
      if (!rst_n) sq_nxt.tag.vld = 1'b0;
      sq_r[j+1] <= sq_nxt;
    end
  end

  // signs, magnitudes and divisor: 32*r at order 1, 32*r2 at order 2
  always_ff @(posedge clk) begin
    logic signed [NUMW-1:0] nre, nim;
    nre = sq_r[RW].num_re;
    nim = sq_r[RW].num_im;
    pm_r.tag    <= rst_n ? sq_r[RW].tag : tag_t'('0);
    pm_r.zero   <= sq_r[RW].zero;
    pm_r.k      <= sq_r[RW].k;
    pm_r.neg_re <= nre[NUMW-1];
    pm_r.neg_im <= nim[NUMW-1];
    pm_r.mag_re <= MW'(nre[NUMW-1] ? -nre : nre);
    pm_r.mag_im <= MW'(nim[NUMW-1] ? -nim : nim);
    if (sq_r[RW].tag.l == ORDER_1) begin
      pm_r.d2 <= DW'(sq_r[RW].res[RW-1:0]) << 5;
    end else begin
      pm_r.d2 <= DW'(sq_r[RW].r2) << 5;
    end
  end

  // constant times magnitude, split in two partial products
  always_ff @(posedge clk) begin
    pp_r.tag    <= rst_n ? pm_r.tag : tag_t'('0);
    pp_r.zero   <= pm_r.zero;
    pp_r.neg_re <= pm_r.neg_re;
    pp_r.neg_im <= pm_r.neg_im;
    pp_r.d2     <= pm_r.d2;
    pp_r.lo_re  <= pm_r.mag_re[LOW-1:0] * pm_r.k;
    pp_r.hi_re  <= pm_r.mag_re[MW-1:LOW] * pm_r.k;
    pp_r.lo_im  <= pm_r.mag_im[LOW-1:0] * pm_r.k;
    pp_r.hi_im  <= pm_r.mag_im[MW-1:LOW] * pm_r.k;
  end

  // dividend 2*k*mag + d, d being half the doubled divisor
  always_ff @(posedge clk) begin
    logic [PW-1:0] pre, pim;
    pre = PW'(pp_r.lo_re) + (PW'(pp_r.hi_re) << LOW);
    pim = PW'(pp_r.lo_im) + (PW'(pp_r.hi_im) << LOW);
    dv_r[0].tag    <= rst_n ? pp_r.tag : tag_t'('0);
    dv_r[0].zero   <= pp_r.zero;
    dv_r[0].neg_re <= pp_r.neg_re;
    dv_r[0].neg_im <= pp_r.neg_im;
    dv_r[0].d2     <= pp_r.d2;
    dv_r[0].rem_re <= (pre << 1) + PW'(pp_r.d2 >> 1);
    dv_r[0].rem_im <= (pim << 1) + PW'(pp_r.d2 >> 1);
    dv_r[0].q_re   <= '0;
    dv_r[0].q_im   <= '0;
  end

  // restoring divider, real and imaginary lanes side by side, msb first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [PW-1:0] dsh;
    assign dsh = PW'(dv_r[j].d2) << SH;
    always_ff @(posedge clk) begin
      dv_t dv_nxt;
      dv_nxt = dv_r[j];
      if (dv_r[j].rem_re >= dsh) begin
        dv_nxt.rem_re   = dv_r[j].rem_re - dsh;
        dv_nxt.q_re[SH] = 1'b1;
      end
      if (dv_r[j].rem_im >= dsh) begin
        dv_nxt.rem_im   = dv_r[j].rem_im - dsh;
        dv_nxt.q_im[SH] = 1'b1;
      end
      if (!rst_n) dv_nxt.tag.vld = 1'b0;
      dv_r[j+1] <= dv_nxt;
    end
  end

  // result register: signs back on, order 0 and zero length overrides
  always_ff @(posedge clk) begin
    logic signed [OW-1:0] qre, qim;
    qre = $signed({1'b0, dv_r[QW].q_re});
    qim = $signed({1'b0, dv_r[QW].q_im});
    out_m_index     <= dv_r[QW].tag.m;
    out_last_of_run <= dv_r[QW].tag.last;
    out_zero_length <= dv_r[QW].zero;
    if (dv_r[QW].tag.l == ORDER_0) begin
      out_real_part <= Y00_VAL;
      out_imag_part <= '0;
    end else if (dv_r[QW].zero) begin
      out_real_part <= '0;
      out_imag_part <= '0;
    end else begin
      out_real_part <= dv_r[QW].neg_re ? -qre : qre;
      out_imag_part <= dv_r[QW].neg_im ? -qim : qim;
    end
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_r[QW].tag.vld;
    end
  end

  // while tokens remain, the entry stage holds a live token
  a_busy_token : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> s0_r.vld)
    else $error("busy without a live entry token");

  // a run leaves on consecutive cycles
  a_run_contig : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid)
    else $error("gap inside a result run");

  // m = 0 has no imaginary part
  a_m0_imag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_m_index == 3'sd0 |-> out_imag_part == '0)
    else $error("imaginary part set for m = 0");

  // zero vector gives a zero real part on every result but the last of a run, so order 0 is left out
  a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length && !out_last_of_run |-> out_real_part == '0)
    else $error("zero length vector gave a non-zero real part");

  // busy only rises from an accepted start
  a_busy_rise : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule
